[rtl/core/fm_index_rank_lf_locate_core_macros.svh]
// Assertion helpers shared by the core RTL.
`ifndef FM_INDEX_RANK_LF_LOCATE_CORE_MACROS_SVH
`define FM_INDEX_RANK_LF_LOCATE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the core clock, off while in reset.
`define FMRL_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("fmrl assertion failed");

// Next-cycle implication, sampled on the core clock, off while in reset.
`define FMRL_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("fmrl assertion failed");

`endif

[rtl/core/fmrl_pkg.sv]
`timescale 1ns / 1ps
package fmrl_pkg;

  localparam int unsigned MAX_ROWS          = 1048576;
  localparam int unsigned MIN_CKPT_STRIDE   = 64;
  localparam int unsigned MIN_SAMPLE_STRIDE = 32;
  localparam int unsigned ALPHABET_SIZE     = 6;

  localparam int unsigned VAL_W       = 21;
  localparam int unsigned SENT_W      = 20;
  localparam int unsigned SA_W        = 20;
  localparam int unsigned SYM_W       = 3;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned LANES       = 4;
  localparam int unsigned CKPT_W      = LANES * VAL_W;
  localparam int unsigned ROW_AW      = $clog2(MAX_ROWS);
  localparam int unsigned CKPT_BLOCKS = MAX_ROWS / MIN_CKPT_STRIDE + 1;
  localparam int unsigned CKPT_AW     = $clog2(CKPT_BLOCKS);
  localparam int unsigned SA_DEPTH    = MAX_ROWS / MIN_SAMPLE_STRIDE + 1;
  localparam int unsigned SA_AW       = $clog2(SA_DEPTH);
  localparam int unsigned DIV_W       = VAL_W + 1;
  localparam int unsigned DIV_CW      = $clog2(DIV_W);
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  localparam logic [SYM_W-1:0] SYM_SENT = 3'd0;
  localparam logic [SYM_W-1:0] SYM_SEP  = 3'd1;
  localparam logic [SYM_W-1:0] SYM_A    = 3'd2;
  localparam logic [SYM_W-1:0] SYM_T    = 3'd5;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_BWT = 3'd0,
    OP_LOAD_SA  = 3'd1,
    OP_LOAD_C   = 3'd2,
    OP_OCC      = 3'd3,
    OP_LF       = 3'd4,
    OP_LOCATE   = 3'd5
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_STEPS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_TEXT_ROWS    = 2'd0,
    REG_SENTINEL_ROW = 2'd1,
    REG_CKPT_STRIDE  = 2'd2,
    REG_SAMPLE_STRIDE = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LD_DIV,
    ST_OCC_START,
    ST_OCC_DIV,
    ST_OCC_CKPT,
    ST_OCC_SCAN,
    ST_OCC_END,
    ST_LF_RD,
    ST_LF_SYM,
    ST_LOC_CHK,
    ST_LOC_DIV,
    ST_LOC_SA,
    ST_LOC_MOD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [VAL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [VAL_W-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/core/fm_index_rank_lf_locate_core.sv]
`timescale 1ns / 1ps
// FM-index engine over a DNA BWT: loads BWT symbols, SA samples and C entries,
// and answers occ, lf and locate queries, one item at a time.
// Input channel: in_valid_i with opcode_i, position_i, symbol_i, load_value_i;
// an item is taken when in_valid_i is high and in_stall_o is low. Each item
// gives exactly one result on the output channel (answer_o, status_o), taken
// when out_valid_o is high and out_stall_i is low.
// C and SA loads write their entry directly; a BWT load also runs the shared
// divider to find checkpoint boundaries. occ of a base divides the position
// by the stride, reads that checkpoint and counts matches from it up to the
// position; lf first reads the symbol of the row. locate costs one lf plus
// one division per step until a sampled row, then one more division for the
// wrap; so the rate is set by the divider and the single BWT memory read port.
// After reset all 16385 checkpoint entries are zeroed, one entry per cycle,
// during which in_stall_o stays high; configuration writes are taken.
// The result sits in an output register; while the receiver stalls it holds,
// the next item is still accepted and runs up to its own result.
`include "fm_index_rank_lf_locate_core_macros.svh"
module fm_index_rank_lf_locate_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fmrl_pkg::OP_W-1:0]     opcode_i,
  input  logic [fmrl_pkg::VAL_W-1:0]    position_i,
  input  logic [fmrl_pkg::SYM_W-1:0]    symbol_i,
  input  logic [fmrl_pkg::VAL_W-1:0]    load_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fmrl_pkg::VAL_W-1:0]    answer_o,
  output logic [fmrl_pkg::STAT_W-1:0]   status_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fmrl_pkg::APB_AW-1:0]   paddr,
  input  logic [fmrl_pkg::APB_DW-1:0]   pwdata,
  output logic [fmrl_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import fmrl_pkg::*;

  localparam logic [VAL_W-1:0] MAX_ROWS_V = VAL_W'(MAX_ROWS);
  localparam logic [VAL_W-1:0] MIN_CK_V   = VAL_W'(MIN_CKPT_STRIDE);
  localparam logic [VAL_W-1:0] MIN_SA_V   = VAL_W'(MIN_SAMPLE_STRIDE);

  // Configuration registers.
  logic [VAL_W-1:0]  text_rows_q, ck_stride_q, sa_stride_q;
  logic [SENT_W-1:0] sentinel_q;
  logic              cfg_we;
  reg_idx_e          cfg_idx;
  logic [VAL_W-1:0]  n_eff, ck_eff, sa_eff;

  state_e state_q, state_d;

  opcode_e          op_q, op_d;
  logic [VAL_W-1:0] pos_q, pos_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] row_q, row_d;
  logic [VAL_W-1:0] steps_q, steps_d;
  logic [VAL_W-1:0] count_q, count_d;
  logic [VAL_W-1:0] cval_q, cval_d;
  logic [SYM_W-1:0] occ_sym_q, occ_sym_d;
  logic [VAL_W-1:0] occ_pos_q, occ_pos_d;
  logic [ROW_AW-1:0] scan_addr_q, scan_addr_d;
  logic [ROW_AW-1:0] scan_prev_q, scan_prev_d;
  logic [VAL_W-1:0] scan_left_q, scan_left_d;
  logic             scan_pend_q, scan_pend_d;
  logic [VAL_W-1:0] answer_q, answer_d;
  status_e          status_q, status_d;
  logic [CKPT_AW-1:0] clr_q, clr_d;
  logic [VAL_W-1:0] rows_loaded_q, rows_loaded_d;
  logic [VAL_W-1:0] cnt_q [LANES];
  logic [VAL_W-1:0] cnt_d [LANES];
  logic [VAL_W-1:0] ctab_q [ALPHABET_SIZE];
  logic [VAL_W-1:0] ctab_d [ALPHABET_SIZE];
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_answer_q, out_answer_d;
  status_e          out_status_q, out_status_d;

  // Memory ports.
  logic               bwt_we;
  logic [ROW_AW-1:0]  bwt_raddr;
  logic [SYM_W-1:0]   bwt_rdata;
  logic               ckpt_we;
  logic [CKPT_AW-1:0] ckpt_waddr;
  logic [CKPT_W-1:0]  ckpt_wdata;
  logic [CKPT_W-1:0]  ckpt_rdata;
  logic               sa_we;
  logic [SA_W-1:0]    sa_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              accept;
  logic              out_free;
  logic              sum_ge_n;
  logic [DIV_W-1:0]  lf_sum;
  logic [SYM_W-1:0]  lf_sym;
  logic [SYM_W-1:0]  scan_sym;
  logic [SYM_W-1:0]  lane_full;
  logic [1:0]        lane;
  logic [VAL_W-1:0]  rows_next;
  logic              load_ok;
  logic              occ_plain;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_rows_q <= VAL_W'(1);
      sentinel_q  <= '0;
      ck_stride_q <= MIN_CK_V;
      sa_stride_q <= MIN_SA_V;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TEXT_ROWS:     text_rows_q <= pwdata[VAL_W-1:0];
        REG_SENTINEL_ROW:  sentinel_q  <= pwdata[SENT_W-1:0];
        REG_CKPT_STRIDE:   ck_stride_q <= pwdata[VAL_W-1:0];
        REG_SAMPLE_STRIDE: sa_stride_q <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TEXT_ROWS:     prdata = {(APB_DW - VAL_W)'(0), text_rows_q};
      REG_SENTINEL_ROW:  prdata = {(APB_DW - SENT_W)'(0), sentinel_q};
      REG_CKPT_STRIDE:   prdata = {(APB_DW - VAL_W)'(0), ck_stride_q};
      REG_SAMPLE_STRIDE: prdata = {(APB_DW - VAL_W)'(0), sa_stride_q};
      default:           prdata = '0;
    endcase
  end

  assign n_eff  = (text_rows_q == '0) ? VAL_W'(1) :
                  ((text_rows_q > MAX_ROWS_V) ? MAX_ROWS_V : text_rows_q);
  assign ck_eff = (ck_stride_q < MIN_CK_V) ? MIN_CK_V :
                  ((ck_stride_q > MAX_ROWS_V) ? MAX_ROWS_V : ck_stride_q);
  assign sa_eff = (sa_stride_q < MIN_SA_V) ? MIN_SA_V :
                  ((sa_stride_q > MAX_ROWS_V) ? MAX_ROWS_V : sa_stride_q);

  // ---------------------------------------------------------------- helpers
  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign lf_sum    = {1'b0, cval_q} + {1'b0, count_q};
  assign sum_ge_n  = lf_sum >= {1'b0, n_eff};
  // The sentinel row always reads as the sentinel, whatever was stored there.
  assign lf_sym    = (row_q == {1'b0, sentinel_q}) ? SYM_SENT : bwt_rdata;
  assign scan_sym  = (scan_prev_q == sentinel_q) ? SYM_SENT : bwt_rdata;
  assign lane_full = occ_sym_q - SYM_A;
  assign lane      = lane_full[1:0];
  assign rows_next = rows_loaded_q + 1'b1;
  assign load_ok   = (pos_q == rows_loaded_q) && (pos_q < n_eff);
  assign occ_plain = (occ_sym_q >= SYM_A) && (occ_sym_q <= SYM_T);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == CKPT_AW'(CKPT_BLOCKS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (op_q)
          OP_LOAD_BWT: state_d = load_ok ? ST_LD_DIV : ST_DONE;
          OP_OCC:      state_d = ST_OCC_START;
          OP_LF:       state_d = (pos_q < n_eff) ? ST_LF_RD : ST_DONE;
          OP_LOCATE:   state_d = (pos_q < n_eff) ? ST_LOC_CHK : ST_DONE;
          default:     state_d = ST_DONE;
        endcase
      end
      ST_LD_DIV: begin
        if (div_rsp.done) state_d = ST_DONE;
      end
      ST_OCC_START: state_d = occ_plain ? ST_OCC_DIV : ST_OCC_END;
      ST_OCC_DIV: begin
        if (div_rsp.done) state_d = ST_OCC_CKPT;
      end
      ST_OCC_CKPT: state_d = ST_OCC_SCAN;
      ST_OCC_SCAN: begin
        if (scan_left_q == '0 && !scan_pend_q) state_d = ST_OCC_END;
      end
      ST_OCC_END: begin
        if (op_q == OP_LOCATE && !sum_ge_n) state_d = ST_LOC_CHK;
        else                                state_d = ST_DONE;
      end
      ST_LF_RD:   state_d = ST_LF_SYM;
      ST_LF_SYM:  state_d = ST_OCC_START;
      ST_LOC_CHK: state_d = ST_LOC_DIV;
      ST_LOC_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            state_d = (div_rsp.quo >= DIV_W'(SA_DEPTH)) ? ST_DONE : ST_LOC_SA;
          end else begin
            state_d = (steps_q >= n_eff) ? ST_DONE : ST_LF_RD;
          end
        end
      end
      ST_LOC_SA: state_d = ST_LOC_MOD;
      ST_LOC_MOD: begin
        if (div_rsp.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    op_d          = op_q;
    pos_d         = pos_q;
    sym_d         = sym_q;
    val_d         = val_q;
    row_d         = row_q;
    steps_d       = steps_q;
    count_d       = count_q;
    cval_d        = cval_q;
    occ_sym_d     = occ_sym_q;
    occ_pos_d     = occ_pos_q;
    scan_addr_d   = scan_addr_q;
    scan_prev_d   = scan_prev_q;
    scan_left_d   = scan_left_q;
    scan_pend_d   = 1'b0;
    answer_d      = answer_q;
    status_d      = status_q;
    clr_d         = clr_q;
    rows_loaded_d = rows_loaded_q;
    cnt_d         = cnt_q;
    ctab_d        = ctab_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_answer_d  = out_answer_q;
    out_status_d  = out_status_q;
    bwt_we        = 1'b0;
    bwt_raddr     = scan_addr_q;
    ckpt_we       = 1'b0;
    ckpt_waddr    = clr_q;
    ckpt_wdata    = '0;
    sa_we         = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = {1'b0, occ_pos_q};
    div_req.den   = ck_eff;

    unique case (state_q)
      ST_CLEAR: begin
        ckpt_we = 1'b1;
        clr_d   = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          op_d     = opcode_e'(opcode_i);
          pos_d    = position_i;
          sym_d    = symbol_i;
          val_d    = load_value_i;
          answer_d = '0;
          status_d = STAT_OK;
        end
      end
      ST_EXEC: begin
        unique case (op_q)
          OP_LOAD_BWT: begin
            if (load_ok) begin
              bwt_we        = 1'b1;
              rows_loaded_d = rows_next;
              if (pos_q != {1'b0, sentinel_q} && sym_q >= SYM_A && sym_q <= SYM_T) begin
                cnt_d[lane_of(sym_q)] = cnt_q[lane_of(sym_q)] + 1'b1;
              end
              div_req.start = 1'b1;
              div_req.num   = {1'b0, rows_next};
              div_req.den   = ck_eff;
            end else begin
              status_d = STAT_RANGE;
            end
          end
          OP_LOAD_SA: begin
            if (pos_q >= VAL_W'(SA_DEPTH)) status_d = STAT_RANGE;
            else                           sa_we    = 1'b1;
          end
          OP_LOAD_C: begin
            if (pos_q >= VAL_W'(ALPHABET_SIZE)) status_d = STAT_RANGE;
            else ctab_d[pos_q[SYM_W-1:0]] = val_q;
          end
          OP_OCC: begin
            occ_sym_d = sym_q;
            occ_pos_d = (pos_q > n_eff) ? n_eff : pos_q;
          end
          OP_LF: begin
            if (pos_q >= n_eff) status_d = STAT_RANGE;
            row_d = pos_q;
          end
          OP_LOCATE: begin
            if (pos_q >= n_eff) status_d = STAT_RANGE;
            row_d   = pos_q;
            steps_d = '0;
          end
          default: status_d = STAT_RANGE;
        endcase
      end
      ST_LD_DIV: begin
        // A checkpoint is stored each time the loaded row count reaches a multiple of the stride.
        ckpt_waddr = div_rsp.quo[CKPT_AW-1:0];
        ckpt_wdata = {cnt_q[3], cnt_q[2], cnt_q[1], cnt_q[0]};
        if (div_rsp.done && div_rsp.rem == '0 && div_rsp.quo < DIV_W'(CKPT_BLOCKS)) begin
          ckpt_we = 1'b1;
        end
      end
      ST_OCC_START: begin
        if (occ_sym_q == SYM_SENT) begin
          count_d = (occ_pos_q > {1'b0, sentinel_q}) ? VAL_W'(1) : '0;
        end else if (!occ_plain) begin
          count_d = '0;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {1'b0, occ_pos_q};
          div_req.den   = ck_eff;
        end
      end
      ST_OCC_DIV: begin
        if (div_rsp.done) begin
          scan_addr_d = ROW_AW'(occ_pos_q - div_rsp.rem);
          scan_left_d = div_rsp.rem;
        end
      end
      ST_OCC_CKPT: begin
        count_d = ckpt_rdata[lane*VAL_W +: VAL_W];
      end
      ST_OCC_SCAN: begin
        // One BWT read issued per cycle; the previous read is counted here.
        if (scan_left_q != '0) begin
          scan_addr_d = scan_addr_q + 1'b1;
          scan_left_d = scan_left_q - 1'b1;
          scan_prev_d = scan_addr_q;
          scan_pend_d = 1'b1;
        end
        if (scan_pend_q && scan_sym == occ_sym_q) count_d = count_q + 1'b1;
      end
      ST_OCC_END: begin
        unique case (op_q)
          OP_OCC: answer_d = count_q;
          OP_LF:  answer_d = lf_sum[VAL_W] ? '1 : lf_sum[VAL_W-1:0];
          OP_LOCATE: begin
            if (sum_ge_n) begin
              status_d = STAT_RANGE;
            end else begin
              row_d   = lf_sum[VAL_W-1:0];
              steps_d = steps_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_LF_RD: begin
        bwt_raddr = row_q[ROW_AW-1:0];
      end
      ST_LF_SYM: begin
        occ_sym_d = lf_sym;
        occ_pos_d = row_q;
        cval_d    = (lf_sym < SYM_W'(ALPHABET_SIZE)) ? ctab_q[lf_sym] : '0;
      end
      ST_LOC_CHK: begin
        div_req.start = 1'b1;
        div_req.num   = {1'b0, row_q};
        div_req.den   = sa_eff;
      end
      ST_LOC_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            if (div_rsp.quo >= DIV_W'(SA_DEPTH)) status_d = STAT_RANGE;
          end else if (steps_q >= n_eff) begin
            status_d = STAT_STEPS;
          end
        end
      end
      ST_LOC_SA: begin
        div_req.start = 1'b1;
        div_req.num   = {(DIV_W - SA_W)'(0), sa_rdata} + {1'b0, steps_q};
        div_req.den   = n_eff;
      end
      ST_LOC_MOD: begin
        if (div_rsp.done) answer_d = div_rsp.rem;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_answer_d = (status_q == STAT_OK) ? answer_q : '0;
          out_status_d = status_q;
        end
      end
      default: ;
    endcase
  end

  function automatic logic [1:0] lane_of(input logic [SYM_W-1:0] s);
    logic [SYM_W-1:0] d;
    d = s - SYM_A;
    return d[1:0];
  endfunction

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      rows_loaded_q <= '0;
      scan_pend_q   <= 1'b0;
      out_valid_q   <= 1'b0;
      for (int k = 0; k < LANES; k++) cnt_q[k] <= '0;
      for (int k = 0; k < ALPHABET_SIZE; k++) ctab_q[k] <= '0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      rows_loaded_q <= rows_loaded_d;
      scan_pend_q   <= scan_pend_d;
      out_valid_q   <= out_valid_d;
      cnt_q         <= cnt_d;
      ctab_q        <= ctab_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    pos_q        <= pos_d;
    sym_q        <= sym_d;
    val_q        <= val_d;
    row_q        <= row_d;
    steps_q      <= steps_d;
    count_q      <= count_d;
    cval_q       <= cval_d;
    occ_sym_q    <= occ_sym_d;
    occ_pos_q    <= occ_pos_d;
    scan_addr_q  <= scan_addr_d;
    scan_prev_q  <= scan_prev_d;
    scan_left_q  <= scan_left_d;
    answer_q     <= answer_d;
    status_q     <= status_d;
    out_answer_q <= out_answer_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = out_answer_q;
  assign status_o    = out_status_q;

  // ---------------------------------------------------------------- units
  fmrl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  fmrl_ram #(.WIDTH(SYM_W), .DEPTH(MAX_ROWS)) u_bwt_ram (
    .clk_i   (clk_i),
    .we_i    (bwt_we),
    .waddr_i (pos_q[ROW_AW-1:0]),
    .wdata_i (sym_q),
    .raddr_i (bwt_raddr),
    .rdata_o (bwt_rdata)
  );

  fmrl_ram #(.WIDTH(CKPT_W), .DEPTH(CKPT_BLOCKS)) u_ckpt_ram (
    .clk_i   (clk_i),
    .we_i    (ckpt_we),
    .waddr_i (ckpt_waddr),
    .wdata_i (ckpt_wdata),
    .raddr_i (div_rsp.quo[CKPT_AW-1:0]),
    .rdata_o (ckpt_rdata)
  );

  fmrl_ram #(.WIDTH(SA_W), .DEPTH(SA_DEPTH)) u_sa_ram (
    .clk_i   (clk_i),
    .we_i    (sa_we),
    .waddr_i (pos_q[SA_AW-1:0]),
    .wdata_i (val_q[SA_W-1:0]),
    .raddr_i (div_rsp.quo[SA_AW-1:0]),
    .rdata_o (sa_rdata)
  );

  // ---------------------------------------------------------------- checks
  `FMRL_ASSERT_NEXT(a_accept_to_exec, in_valid_i && !in_stall_o, state_q == ST_EXEC)
  `FMRL_ASSERT_IMPL(a_div_done_waited, div_rsp.done, state_q == ST_LD_DIV || state_q == ST_OCC_DIV || state_q == ST_LOC_DIV || state_q == ST_LOC_MOD)
  `FMRL_ASSERT_IMPL(a_scan_pend_in_scan, scan_pend_q, state_q == ST_OCC_SCAN)

endmodule

[rtl/core/fmrl_ram.sv]
`timescale 1ns / 1ps
module fmrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/fmrl_div.sv]
`timescale 1ns / 1ps
module fmrl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fmrl_pkg::div_req_t req_i,
  output fmrl_pkg::div_rsp_t rsp_o
);
  import fmrl_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  num_q, num_d;
  logic [VAL_W-1:0]  den_q, den_d;
  logic [VAL_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  trial;
  logic [DIV_W-1:0]  diff;
  logic              ge;

  // Restoring division, one quotient bit per cycle shifted into num_q.
  assign trial = {rem_q, num_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      num_d = {num_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

[tb/fm_index_rank_lf_locate_core_tb.sv]
`timescale 1ns / 1ps
module fm_index_rank_lf_locate_core_tb;
  import fmrl_pkg::*;

  localparam logic [OP_W-1:0]  OP_BAD6   = 3'd6;
  localparam logic [OP_W-1:0]  OP_BAD7   = 3'd7;
  localparam logic [SYM_W-1:0] SYM_BAD6  = 3'd6;
  localparam logic [SYM_W-1:0] SYM_BAD7  = 3'd7;
  localparam int unsigned      VAL_MAX   = (1 << VAL_W) - 1;
  localparam int unsigned      SENT_MAX  = (1 << SENT_W) - 1;
  localparam int unsigned      MAX_TEXT  = 256;
  localparam longint unsigned  LIMIT     = 40000000;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] pos;
    logic [SYM_W-1:0] sym;
    logic [VAL_W-1:0] val;
  } fm_item_t;

  typedef struct {
    logic [VAL_W-1:0]  answer;
    logic [STAT_W-1:0] status;
  } fm_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     opcode_i = '0;
  logic [VAL_W-1:0]    position_i = '0;
  logic [SYM_W-1:0]    symbol_i = '0;
  logic [VAL_W-1:0]    load_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [VAL_W-1:0]    answer_o;
  logic [STAT_W-1:0]   status_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  fm_index_rank_lf_locate_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .opcode_i(opcode_i), .position_i(position_i), .symbol_i(symbol_i),
    .load_value_i(load_value_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .answer_o(answer_o), .status_o(status_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the engine: memories, counters and registers.
  logic [SYM_W-1:0] bwt_mem [0:MAX_ROWS-1];
  int unsigned      ckpt_mem [0:CKPT_BLOCKS*LANES-1];
  int unsigned      sa_mem [0:SA_DEPTH-1];
  int unsigned      c_mem [0:ALPHABET_SIZE-1];
  int unsigned      run_cnt [0:LANES-1];
  int unsigned      rows_done;
  int unsigned      cfg_rows = 1, cfg_sent = 0, cfg_ckpt = 64, cfg_samp = 32;

  fm_item_t    pend_q[$];
  fm_result_t  expected_q[$];
  fm_item_t    cur_item;
  int unsigned send_idle = 0, recv_idle = 0;
  int unsigned n_sent = 0, n_checked = 0, n_errors = 0;
  longint unsigned cycles = 0;

  // Text, suffix array and C table of the generated genome.
  int unsigned txt [0:MAX_TEXT-1];
  int unsigned sa_ord [0:MAX_TEXT-1];
  int unsigned true_c [0:ALPHABET_SIZE-1];
  int unsigned txt_len, sent_pos;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned rows_eff();
    return clamp(cfg_rows, 1, MAX_ROWS);
  endfunction

  function automatic int unsigned ckpt_eff();
    return clamp(cfg_ckpt, MIN_CKPT_STRIDE, MAX_ROWS);
  endfunction

  function automatic int unsigned samp_eff();
    return clamp(cfg_samp, MIN_SAMPLE_STRIDE, MAX_ROWS);
  endfunction

  function automatic int unsigned sym_at(int unsigned row);
    if (row == cfg_sent) return SYM_SENT;
    if (row >= MAX_ROWS) return SYM_SENT;
    return bwt_mem[row];
  endfunction

  function automatic int unsigned occ_count(int unsigned sym, int unsigned pos);
    int unsigned p, blk, cnt;
    p = (pos > rows_eff()) ? rows_eff() : pos;
    if (sym == SYM_SENT) return (p > cfg_sent) ? 1 : 0;
    if (sym == SYM_SEP || sym > SYM_T) return 0;
    blk = p / ckpt_eff();
    cnt = (blk < CKPT_BLOCKS) ? ckpt_mem[blk*LANES + sym - SYM_A] : 0;
    for (int unsigned r = blk * ckpt_eff(); r < p; r++)
      if (sym_at(r) == sym) cnt++;
    return cnt;
  endfunction

  function automatic int unsigned lf_row(int unsigned row);
    int unsigned s, c;
    s = sym_at(row);
    c = (s < ALPHABET_SIZE) ? c_mem[s] : 0;
    return c + occ_count(s, row);
  endfunction

  function automatic fm_result_t predict(fm_item_t it);
    fm_result_t  res;
    int unsigned n, ans, row, steps, blk;
    logic [1:0]  st;
    n   = rows_eff();
    ans = 0;
    st  = STAT_OK;
    case (it.op)
      OP_LOAD_BWT: begin
        if (it.pos != rows_done || it.pos >= n) begin
          st = STAT_RANGE;
        end else begin
          bwt_mem[it.pos] = it.sym;
          if (it.pos != cfg_sent && it.sym >= SYM_A && it.sym <= SYM_T)
            run_cnt[it.sym - SYM_A]++;
          rows_done++;
          if (rows_done % ckpt_eff() == 0) begin
            blk = rows_done / ckpt_eff();
            if (blk < CKPT_BLOCKS)
              for (int k = 0; k < LANES; k++)
                ckpt_mem[blk*LANES + k] = run_cnt[k] & VAL_MAX;
          end
        end
      end
      OP_LOAD_SA: begin
        if (it.pos >= SA_DEPTH) st = STAT_RANGE;
        else sa_mem[it.pos] = it.val & SENT_MAX;
      end
      OP_LOAD_C: begin
        if (it.pos >= ALPHABET_SIZE) st = STAT_RANGE;
        else c_mem[it.pos] = it.val;
      end
      OP_OCC: ans = occ_count(it.sym, it.pos);
      OP_LF: begin
        if (it.pos >= n) st = STAT_RANGE;
        else begin
          ans = lf_row(it.pos);
          if (ans > VAL_MAX) ans = VAL_MAX;
        end
      end
      OP_LOCATE: begin
        row   = it.pos;
        steps = 0;
        if (row >= n) st = STAT_RANGE;
        else begin
          while (row % samp_eff() != 0) begin
            if (steps >= n) begin
              st = STAT_STEPS;
              break;
            end
            row = lf_row(row);
            if (row >= n) begin
              st = STAT_RANGE;
              break;
            end
            steps++;
          end
          if (st == STAT_OK) begin
            if (row / samp_eff() >= SA_DEPTH) st = STAT_RANGE;
            else ans = (longint'(sa_mem[row / samp_eff()]) + steps) % n;
          end
        end
      end
      default: st = STAT_RANGE;
    endcase
    if (st != STAT_OK) ans = 0;
    res.answer = ans[VAL_W-1:0];
    res.status = st;
    return res;
  endfunction

  // Driver: the expectation is worked out when the item is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      opcode_i     <= '0;
      position_i   <= '0;
      symbol_i     <= '0;
      load_value_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(predict(cur_item));
        n_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_item     = pend_q.pop_front();
          in_valid_i   <= 1'b1;
          opcode_i     <= cur_item.op;
          position_i   <= cur_item.pos;
          symbol_i     <= cur_item.sym;
          load_value_i <= cur_item.val;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: answer %0d status %0d", answer_o, status_o);
          n_errors++;
        end else begin
          fm_result_t exp_r;
          exp_r = expected_q.pop_front();
          if (answer_o !== exp_r.answer) begin
            $error("answer: expected %0d, got %0d", exp_r.answer, answer_o);
            n_errors++;
          end
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
            n_errors++;
          end
          n_checked++;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add(logic [OP_W-1:0] op, int unsigned pos, int unsigned sym,
                     int unsigned val);
    fm_item_t it;
    it.op  = op;
    it.pos = pos[VAL_W-1:0];
    it.sym = sym[SYM_W-1:0];
    it.val = val[VAL_W-1:0];
    pend_q.push_back(it);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || in_valid_i || expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, int unsigned data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_TEXT_ROWS:     cfg_rows = data & VAL_MAX;
      REG_SENTINEL_ROW:  cfg_sent = data & SENT_MAX;
      REG_CKPT_STRIDE:   cfg_ckpt = data & VAL_MAX;
      REG_SAMPLE_STRIDE: cfg_samp = data & VAL_MAX;
      default: ;
    endcase
  endtask

  function automatic bit suffix_less(int unsigned a, int unsigned b);
    for (int unsigned k = 0; k < MAX_TEXT; k++)
      if (txt[a+k] != txt[b+k]) return txt[a+k] < txt[b+k];
    return 0;
  endfunction

  task automatic load_samples(int unsigned stride);
    for (int unsigned k = 0; k * stride < txt_len; k++)
      add(OP_LOAD_SA, k, $urandom_range(7), sa_ord[k*stride]);
  endtask

  // Random queries; in the wide phase lf and locate rows may reach past the loaded text.
  task automatic random_queries(int unsigned count, bit wide);
    int unsigned r, p;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        p = ($urandom_range(9) < 8 || wide) ? $urandom_range(txt_len) : ($urandom & VAL_MAX);
        add(OP_OCC, p, $urandom_range(7), $urandom);
      end else if (r < 55) begin
        if ($urandom_range(9) < 9) p = $urandom_range(txt_len - 1);
        else p = $urandom_range(VAL_MAX, wide ? MAX_ROWS : txt_len);
        add(OP_LF, p, $urandom_range(7), $urandom);
      end else if (r < 85) begin
        if (wide) p = $urandom_range(1) ? 0 : $urandom_range(VAL_MAX, MAX_ROWS);
        else if ($urandom_range(9) < 9) p = $urandom_range(txt_len - 1);
        else p = $urandom_range(VAL_MAX, txt_len);
        add(OP_LOCATE, p, $urandom_range(7), $urandom);
      end else if (r < 90) begin
        p = $urandom_range(3) ? $urandom_range(40) : ($urandom & VAL_MAX);
        add(OP_LOAD_SA, p, $urandom_range(7), $urandom);
      end else if (r < 94) begin
        add(OP_LOAD_C, $urandom_range(VAL_MAX, ALPHABET_SIZE), $urandom_range(7), $urandom);
      end else if (r < 97) begin
        p = $urandom & VAL_MAX;
        if (p == rows_done) p++;
        add(OP_LOAD_BWT, p, $urandom_range(7), $urandom);
      end else begin
        add($urandom_range(1) ? OP_BAD6 : OP_BAD7, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int unsigned tmp, s, fix_row, fix_sym, bsym;
    int unsigned cnt [0:ALPHABET_SIZE-1];

    foreach (ckpt_mem[i]) ckpt_mem[i] = 0;
    foreach (c_mem[i]) c_mem[i] = 0;
    foreach (run_cnt[i]) run_cnt[i] = 0;
    foreach (cnt[i]) cnt[i] = 0;
    rows_done = 0;

    // Random genome ended by the sentinel, sorted naively into its suffix array.
    txt_len = $urandom_range(220, 130);
    foreach (txt[i]) txt[i] = SYM_SENT;
    for (int unsigned i = 0; i + 1 < txt_len; i++) begin
      txt[i] = $urandom_range(SYM_T, SYM_A);
      cnt[txt[i]]++;
    end
    for (int unsigned i = 0; i < txt_len; i++) sa_ord[i] = i;
    for (int unsigned i = 1; i < txt_len; i++)
      for (int j = i; j > 0 && suffix_less(sa_ord[j], sa_ord[j-1]); j--) begin
        tmp = sa_ord[j]; sa_ord[j] = sa_ord[j-1]; sa_ord[j-1] = tmp;
      end
    for (int unsigned i = 0; i < txt_len; i++)
      if (sa_ord[i] == 0) sent_pos = i;
    true_c[SYM_SENT] = 0;
    true_c[SYM_SEP]  = 1;
    true_c[SYM_A]    = 1;
    for (int unsigned k = SYM_A + 1; k <= SYM_T; k++) true_c[k] = true_c[k-1] + cnt[k-1];

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks under the reset settings, nothing of the BWT loaded.
    send_idle = 27;
    recv_idle = 77;
    add(OP_LOAD_SA, 0, SYM_BAD7, $urandom);
    add(OP_LOAD_SA, SA_DEPTH, 0, VAL_MAX);
    add(OP_LOAD_SA, VAL_MAX, 0, 0);
    add(OP_LOAD_C, ALPHABET_SIZE, 0, VAL_MAX);
    add(OP_LOAD_C, VAL_MAX, 0, 0);
    add(OP_LOAD_BWT, 3, SYM_A, 0);
    add(OP_LOAD_BWT, VAL_MAX, SYM_BAD7, VAL_MAX);
    for (int unsigned k = 0; k < 8; k++) add(OP_OCC, 0, k, 0);
    add(OP_OCC, VAL_MAX, SYM_SENT, 0);
    add(OP_OCC, VAL_MAX, SYM_SEP, 0);
    add(OP_LF, 1, 0, 0);
    add(OP_LF, VAL_MAX, 0, 0);
    add(OP_LOCATE, 0, 0, 0);
    add(OP_LOCATE, VAL_MAX, 0, 0);
    add(OP_BAD6, VAL_MAX, SYM_BAD7, VAL_MAX);
    add(OP_BAD7, 0, 0, 0);
    drain();

    // Load the whole index with consistent settings.
    reg_write(REG_TEXT_ROWS, txt_len);
    reg_write(REG_SENTINEL_ROW, sent_pos);
    reg_write(REG_CKPT_STRIDE, 64);
    reg_write(REG_SAMPLE_STRIDE, 32);
    for (int unsigned i = 0; i < txt_len; i++) begin
      if (i == sent_pos) begin
        // The sentinel row is read as sentinel whatever is stored there.
        case ($urandom_range(3))
          0: bsym = SYM_SENT;
          1: bsym = SYM_SEP;
          2: bsym = SYM_BAD6;
          default: bsym = SYM_BAD7;
        endcase
      end else begin
        bsym = txt[sa_ord[i] - 1];
      end
      add(OP_LOAD_BWT, i, bsym, $urandom);
    end
    add(OP_LOAD_BWT, txt_len, SYM_A, 0);
    load_samples(32);
    for (int unsigned k = 0; k < ALPHABET_SIZE; k++) add(OP_LOAD_C, k, 0, true_c[k]);
    drain();

    random_queries(350, 0);
    drain();

    // A self-looping row drives locate into the step limit, and a huge
    // C entry makes lf saturate.
    fix_row = 0;
    for (int unsigned r = txt_len - 1; r > 0 && fix_row == 0; r--) begin
      s = sym_at(r);
      if (r % 32 != 0 && s >= SYM_A && s <= SYM_T && occ_count(s, r) > 0) begin
        fix_row = r;
        fix_sym = s;
      end
    end
    if (fix_row != 0) begin
      add(OP_LOAD_C, fix_sym, 0, fix_row - occ_count(fix_sym, fix_row));
      add(OP_LF, fix_row, 0, 0);
      add(OP_LOCATE, fix_row, 0, 0);
      add(OP_LOAD_C, fix_sym, 0, VAL_MAX);
      add(OP_LF, fix_row, 0, 0);
      add(OP_LOAD_C, fix_sym, 0, true_c[fix_sym]);
      drain();
    end

    // Register extremes: largest text, far sentinel, strides saturated high.
    send_idle = 77;
    recv_idle = 27;
    reg_write(REG_TEXT_ROWS, VAL_MAX);
    reg_write(REG_SENTINEL_ROW, SENT_MAX);
    reg_write(REG_CKPT_STRIDE, VAL_MAX);
    reg_write(REG_SAMPLE_STRIDE, VAL_MAX);
    random_queries(150, 1);
    drain();

    // Back to the real text, a checkpoint stride below its minimum and a wider sample.
    reg_write(REG_TEXT_ROWS, txt_len);
    reg_write(REG_SENTINEL_ROW, sent_pos);
    reg_write(REG_CKPT_STRIDE, 0);
    reg_write(REG_SAMPLE_STRIDE, 64);
    load_samples(64);
    random_queries(250, 0);
    drain();

    send_idle = 0;
    recv_idle = 0;
    reg_write(REG_SAMPLE_STRIDE, 1);
    load_samples(32);
    random_queries(250, 0);
    drain();
    repeat (100) @(posedge clk_i);

    $display("Ran %0d items and checked %0d results on a %0d-row BWT text,",
             n_sent, n_checked, txt_len);
    $display("covering loads, occ, lf and locate under five register settings.");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/fmrl_pkg.sv
rtl/core/fmrl_ram.sv
rtl/core/fmrl_div.sv
rtl/core/fm_index_rank_lf_locate_core.sv
tb/fm_index_rank_lf_locate_core_tb.sv
